>>> hw/rtl/hppc_pkg.sv
// Shared types, codes and constants of the house pressure pump controller.
// No dependencies; every other file of the block refers to this package by scoped names.
package hppc_pkg;

    // Field widths
    localparam int unsigned PRES_W = 14;
    localparam int unsigned FREQ_W = 14;
    localparam int unsigned CURR_W = 13;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned TRIP_W = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 24;

    // Protection timing and thresholds
    localparam logic [TIME_W-1:0] OVERLOAD_DELAY_MS = 32'd5000;
    localparam logic [TIME_W-1:0] DRY_DELAY_MS = 32'd10000;
    localparam logic [TIME_W-1:0] STARTUP_GRACE_MS = 32'd5000;
    localparam logic [PRES_W-1:0] TRIP_PRESSURE_MBAR = 14'd6000;
    localparam logic [CURR_W-1:0] NO_CURRENT_CA = 13'd5;

    // Register values after reset
    localparam logic [PRES_W-1:0] RST_START_PRESSURE = 14'd2000;
    localparam logic [PRES_W-1:0] RST_STOP_PRESSURE = 14'd3500;
    localparam logic [PRES_W-1:0] RST_TARGET_PRESSURE = 14'd3000;
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ = 14'd2500;
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ = 14'd5000;
    localparam logic [CURR_W-1:0] RST_EMERGENCY_CURRENT = 13'd2000;
    localparam logic [CURR_W-1:0] RST_OVERLOAD_CURRENT = 13'd1500;
    localparam logic [CURR_W-1:0] RST_DRY_CURRENT = 13'd200;

    // Trip flag bit positions
    localparam int unsigned TRIP_EMERGENCY = 0;
    localparam int unsigned TRIP_OVERLOAD = 1;
    localparam int unsigned TRIP_DRY = 2;
    localparam int unsigned TRIP_NO_CURRENT = 3;
    localparam int unsigned TRIP_OVERPRESSURE = 4;

    typedef enum logic [1:0] {
        ACT_TICK      = 2'd0,
        ACT_FORCE_ON  = 2'd1,
        ACT_FORCE_OFF = 2'd2,
        ACT_CLEAR     = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_PRESSURE    = 3'd0,
        CFG_STOP_PRESSURE     = 3'd1,
        CFG_TARGET_PRESSURE   = 3'd2,
        CFG_MIN_FREQ          = 3'd3,
        CFG_MAX_FREQ          = 3'd4,
        CFG_EMERGENCY_CURRENT = 3'd5,
        CFG_OVERLOAD_CURRENT  = 3'd6,
        CFG_DRY_CURRENT       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [PRES_W-1:0] start_pressure_mbar;
        logic [PRES_W-1:0] stop_pressure_mbar;
        logic [PRES_W-1:0] target_pressure_mbar;
        logic [FREQ_W-1:0] min_freq_chz;
        logic [FREQ_W-1:0] max_freq_chz;
        logic [CURR_W-1:0] emergency_current_ca;
        logic [CURR_W-1:0] overload_current_ca;
        logic [CURR_W-1:0] dry_current_ca;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] now_ms;
        logic              emergency_stop;
        logic              telemetry_valid;
        logic              level_low_sensor;
        logic              level_mid_sensor;
        logic [PRES_W-1:0] pressure_mbar;
        logic [CURR_W-1:0] current_ca;
    } item_t;

    typedef struct packed {
        logic              run_flag;
        logic [FREQ_W-1:0] freq_now;
        logic [TIME_W-1:0] run_start_ms;
        logic [TIME_W-1:0] overload_start_ms;
        logic [TIME_W-1:0] dry_start_ms;
        logic              blocked_flag;
        logic              alarm_flag;
        logic              force_flag;
    } state_t;

    typedef struct packed {
        logic              pump_run;
        logic [FREQ_W-1:0] drive_freq_chz;
        logic              pump_blocked;
        logic              pump_alarm;
        logic              force_active;
        logic [TRIP_W-1:0] trip_flags;
    } result_t;

endpackage

>>> hw/rtl/hppc_cfg.sv
// Configuration register file of the pump controller: eight threshold registers.
// Depends on hppc_pkg for the register index codes, widths and reset values.
module hppc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hppc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hppc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output hppc_pkg::cfg_t                      cfg
);

    hppc_pkg::cfg_t cfg_reg;
    hppc_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (hppc_pkg::cfg_idx_t'(cfg_index))
                hppc_pkg::CFG_START_PRESSURE:    cfg_next.start_pressure_mbar = cfg_data;
                hppc_pkg::CFG_STOP_PRESSURE:     cfg_next.stop_pressure_mbar = cfg_data;
                hppc_pkg::CFG_TARGET_PRESSURE:   cfg_next.target_pressure_mbar = cfg_data;
                hppc_pkg::CFG_MIN_FREQ:          cfg_next.min_freq_chz = cfg_data;
                hppc_pkg::CFG_MAX_FREQ:          cfg_next.max_freq_chz = cfg_data;
                hppc_pkg::CFG_EMERGENCY_CURRENT:
                    cfg_next.emergency_current_ca = cfg_data[hppc_pkg::CURR_W-1:0];
                hppc_pkg::CFG_OVERLOAD_CURRENT:
                    cfg_next.overload_current_ca = cfg_data[hppc_pkg::CURR_W-1:0];
                hppc_pkg::CFG_DRY_CURRENT:
                    cfg_next.dry_current_ca = cfg_data[hppc_pkg::CURR_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; reset loads the default thresholds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_pressure_mbar  <= hppc_pkg::RST_START_PRESSURE;
            cfg_reg.stop_pressure_mbar   <= hppc_pkg::RST_STOP_PRESSURE;
            cfg_reg.target_pressure_mbar <= hppc_pkg::RST_TARGET_PRESSURE;
            cfg_reg.min_freq_chz         <= hppc_pkg::RST_MIN_FREQ;
            cfg_reg.max_freq_chz         <= hppc_pkg::RST_MAX_FREQ;
            cfg_reg.emergency_current_ca <= hppc_pkg::RST_EMERGENCY_CURRENT;
            cfg_reg.overload_current_ca  <= hppc_pkg::RST_OVERLOAD_CURRENT;
            cfg_reg.dry_current_ca       <= hppc_pkg::RST_DRY_CURRENT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/hppc_step.sv
// Combinational update of the pump controller for one word: house logic, then protections.
// Depends on hppc_pkg for the item, state, result and configuration types.
module hppc_step (
    input  hppc_pkg::cfg_t    cfg,
    input  hppc_pkg::state_t  state,
    input  hppc_pkg::item_t   item,
    output hppc_pkg::state_t  state_next,
    output hppc_pkg::result_t result
);

    logic                               run_h;
    logic [hppc_pkg::FREQ_W-1:0]        freq_h;
    logic [hppc_pkg::TIME_W-1:0]        run_start_h;
    logic [hppc_pkg::TIME_W-1:0]        ol_start;
    logic [hppc_pkg::TIME_W-1:0]        dry_start;
    logic [hppc_pkg::TRIP_W-1:0]        flags;
    logic signed [hppc_pkg::PRES_W:0]   press_err;
    logic signed [hppc_pkg::PRES_W+2:0] freq_raw;
    logic [hppc_pkg::FREQ_W-1:0]        freq_clamp;
    logic                               stay_off;
    logic                               run_h_pre;

    // Proportional command: min + 2 * (target - pressure), clamped to [min, max]
    always_comb begin
        press_err = $signed({1'b0, cfg.target_pressure_mbar})
                  - $signed({1'b0, item.pressure_mbar});
        freq_raw  = $signed({3'b000, cfg.min_freq_chz})
                  + $signed({press_err[hppc_pkg::PRES_W], press_err, 1'b0});
        if (press_err[hppc_pkg::PRES_W]) begin
            freq_clamp = cfg.min_freq_chz;
        end else if (freq_raw > $signed({3'b000, cfg.max_freq_chz})) begin
            freq_clamp = cfg.max_freq_chz;
        end else begin
            freq_clamp = freq_raw[hppc_pkg::FREQ_W-1:0];
        end
    end

    // House logic: inhibit, tank level, hysteresis or force
    always_comb begin
        run_h       = 1'b0;
        freq_h      = state.freq_now;
        run_start_h = state.run_start_ms;
        run_h_pre   = 1'b0;
        stay_off    = item.emergency_stop || !item.telemetry_valid || state.blocked_flag
                   || (!state.force_flag
                       && !(item.level_low_sensor && item.level_mid_sensor));
        if (stay_off) begin
            freq_h = cfg.min_freq_chz;
        end else if (state.force_flag) begin
            run_h = 1'b1;
        end else begin
            run_h_pre = state.run_flag || (item.pressure_mbar <= cfg.start_pressure_mbar);
            if (run_h_pre && (item.pressure_mbar >= cfg.stop_pressure_mbar)) begin
                freq_h = cfg.min_freq_chz;
            end else begin
                run_h = run_h_pre;
            end
        end
        if (run_h && !state.run_flag) begin
            run_start_h = item.now_ms;
        end
        if (run_h) begin
            freq_h = freq_clamp;
        end
    end

    // Protections: only for a pump that runs after the house logic
    always_comb begin
        flags     = '0;
        ol_start  = state.overload_start_ms;
        dry_start = state.dry_start_ms;
        if (run_h) begin
            if (item.current_ca >= cfg.emergency_current_ca) begin
                flags[hppc_pkg::TRIP_EMERGENCY] = 1'b1;
            end
            if (item.current_ca >= cfg.overload_current_ca) begin
                if (ol_start == '0) begin
                    ol_start = item.now_ms;
                end
                if ((item.now_ms - ol_start) > hppc_pkg::OVERLOAD_DELAY_MS) begin
                    flags[hppc_pkg::TRIP_OVERLOAD] = 1'b1;
                end
            end else begin
                ol_start = '0;
            end
            if (item.current_ca < cfg.dry_current_ca) begin
                if (dry_start == '0) begin
                    dry_start = item.now_ms;
                end
                if ((item.now_ms - dry_start) > hppc_pkg::DRY_DELAY_MS) begin
                    flags[hppc_pkg::TRIP_DRY] = 1'b1;
                end
            end else begin
                dry_start = '0;
            end
            if (((item.now_ms - run_start_h) > hppc_pkg::STARTUP_GRACE_MS)
                && (item.current_ca <= hppc_pkg::NO_CURRENT_CA)) begin
                flags[hppc_pkg::TRIP_NO_CURRENT] = 1'b1;
            end
            if (item.pressure_mbar >= hppc_pkg::TRIP_PRESSURE_MBAR) begin
                flags[hppc_pkg::TRIP_OVERPRESSURE] = 1'b1;
            end
        end
    end

    // Select command or tick update; a trip stops, blocks, alarms and drops force
    always_comb begin
        state_next        = state;
        result.trip_flags = '0;
        case (hppc_pkg::action_t'(item.action))
            hppc_pkg::ACT_FORCE_ON:  state_next.force_flag = 1'b1;
            hppc_pkg::ACT_FORCE_OFF: state_next.force_flag = 1'b0;
            hppc_pkg::ACT_CLEAR: begin
                state_next.blocked_flag = 1'b0;
                state_next.alarm_flag   = 1'b0;
            end
            hppc_pkg::ACT_TICK: begin
                state_next.run_flag          = run_h;
                state_next.freq_now          = freq_h;
                state_next.run_start_ms      = run_start_h;
                state_next.overload_start_ms = ol_start;
                state_next.dry_start_ms      = dry_start;
                result.trip_flags            = flags;
                if (flags != '0) begin
                    state_next.run_flag     = 1'b0;
                    state_next.blocked_flag = 1'b1;
                    state_next.alarm_flag   = 1'b1;
                    state_next.force_flag   = 1'b0;
                end
            end
            default: state_next = state;
        endcase
        result.pump_run       = state_next.run_flag;
        result.drive_freq_chz = state_next.freq_now;
        result.pump_blocked   = state_next.blocked_flag;
        result.pump_alarm     = state_next.alarm_flag;
        result.force_active   = state_next.force_flag;
    end

endmodule

>>> hw/rtl/house_pressure_pump_controller.sv
// Top level of the house pressure pump controller: input register, controller state,
// result register. Depends on hppc_pkg, hppc_cfg and hppc_step.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tuser action, s_tdata sensor word
//   m_      | out | m_tvalid/m_tready  | m_tdata pump command and status word
//   cfg_    | in  | cfg_wr_en          | cfg_index, cfg_data
//
// A word is taken into the input register; once the result register is free or being emptied,
// its state update and result are computed in one pass and land in the state and result
// registers, one word per cycle sustained while m_tready stays high.
// Reset is synchronous, active low, and returns thresholds and state to defaults.
// A result held by m_tready low keeps the input register full; s_tready then drops.
module house_pressure_pump_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_ms, [32] emergency_stop, [33] telemetry_valid, [34] level_low_sensor,
    // [35] level_mid_sensor, [49:36] pressure_mbar, [62:50] current_ca, [63] zero
    input  logic [hppc_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [hppc_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] pump_run, [14:1] drive_freq_chz, [15] pump_blocked, [16] pump_alarm,
    // [17] force_active, [22:18] trip_flags, [23] zero
    output logic [hppc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [hppc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hppc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    hppc_pkg::cfg_t    cfg;
    hppc_pkg::item_t   s_item;
    hppc_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    hppc_pkg::state_t  state_reg;
    hppc_pkg::state_t  state_next;
    hppc_pkg::result_t result;
    hppc_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              s_accept;
    logic              proc_fire;

    hppc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hppc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Unpack the input word
    always_comb begin
        s_item.action           = s_tuser;
        s_item.now_ms           = s_tdata[31:0];
        s_item.emergency_stop   = s_tdata[32];
        s_item.telemetry_valid  = s_tdata[33];
        s_item.level_low_sensor = s_tdata[34];
        s_item.level_mid_sensor = s_tdata[35];
        s_item.pressure_mbar    = s_tdata[49:36];
        s_item.current_ca       = s_tdata[62:50];
    end

    // Advance when the result register is free or being emptied
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.run_flag          <= 1'b0;
            state_reg.freq_now          <= hppc_pkg::RST_MIN_FREQ;
            state_reg.run_start_ms      <= '0;
            state_reg.overload_start_ms <= '0;
            state_reg.dry_start_ms      <= '0;
            state_reg.blocked_flag      <= 1'b0;
            state_reg.alarm_flag        <= 1'b0;
            state_reg.force_flag        <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: capture the input word, hold the result until taken
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (proc_fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.trip_flags, out_reg.force_active, out_reg.pump_alarm,
                       out_reg.pump_blocked, out_reg.drive_freq_chz, out_reg.pump_run};

endmodule

>>> tb/sv/house_pressure_pump_controller_test.sv
// Self-checking testbench of the house pressure pump controller: a scoreboard class that
// predicts every status word, and plain tasks that drive the stream and register ports.
// Depends on hppc_pkg and the house_pressure_pump_controller RTL.
`timescale 1ns / 1ps

import hppc_pkg::*;

// Predict the status word for each accepted sensor word and compare results in order
class pump_scoreboard;
    cfg_t        regs;
    state_t      st;
    result_t     pending_results[$];
    int unsigned errors;
    int unsigned checked;

    function new();
        regs.start_pressure_mbar  = RST_START_PRESSURE;
        regs.stop_pressure_mbar   = RST_STOP_PRESSURE;
        regs.target_pressure_mbar = RST_TARGET_PRESSURE;
        regs.min_freq_chz         = RST_MIN_FREQ;
        regs.max_freq_chz         = RST_MAX_FREQ;
        regs.emergency_current_ca = RST_EMERGENCY_CURRENT;
        regs.overload_current_ca  = RST_OVERLOAD_CURRENT;
        regs.dry_current_ca       = RST_DRY_CURRENT;
        st = '0;
        st.freq_now = RST_MIN_FREQ;
        errors  = 0;
        checked = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_START_PRESSURE:    regs.start_pressure_mbar  = v;
            CFG_STOP_PRESSURE:     regs.stop_pressure_mbar   = v;
            CFG_TARGET_PRESSURE:   regs.target_pressure_mbar = v;
            CFG_MIN_FREQ:          regs.min_freq_chz         = v;
            CFG_MAX_FREQ:          regs.max_freq_chz         = v;
            CFG_EMERGENCY_CURRENT: regs.emergency_current_ca = v[CURR_W-1:0];
            CFG_OVERLOAD_CURRENT:  regs.overload_current_ca  = v[CURR_W-1:0];
            default:               regs.dry_current_ca       = v[CURR_W-1:0];
        endcase
    endfunction

    // Lock the pump out after a protection fires
    function void trip();
        st.blocked_flag = 1'b1;
        st.alarm_flag   = 1'b1;
        st.run_flag     = 1'b0;
        st.force_flag   = 1'b0;
    endfunction

    function void note_word(item_t w);
        result_t           r;
        logic [TRIP_W-1:0] trips;
        logic              was_running;
        int                x;
        int                lo;
        int                hi;

        trips = '0;
        case (action_t'(w.action))
            ACT_FORCE_ON:  st.force_flag = 1'b1;
            ACT_FORCE_OFF: st.force_flag = 1'b0;
            ACT_CLEAR: begin
                st.blocked_flag = 1'b0;
                st.alarm_flag   = 1'b0;
            end
            default: begin
                // House logic: inhibits first, then hysteresis or force
                was_running = st.run_flag;
                if (w.emergency_stop || !w.telemetry_valid || st.blocked_flag ||
                    (!st.force_flag && !(w.level_low_sensor && w.level_mid_sensor))) begin
                    st.run_flag = 1'b0;
                    st.freq_now = regs.min_freq_chz;
                end else begin
                    if (st.force_flag) begin
                        st.run_flag = 1'b1;
                    end else begin
                        if (!st.run_flag && w.pressure_mbar <= regs.start_pressure_mbar)
                            st.run_flag = 1'b1;
                        if (st.run_flag && w.pressure_mbar >= regs.stop_pressure_mbar) begin
                            st.run_flag = 1'b0;
                            st.freq_now = regs.min_freq_chz;
                        end
                    end
                    if (st.run_flag && !was_running)
                        st.run_start_ms = w.now_ms;
                    // Proportional command, clamped low side first
                    if (st.run_flag) begin
                        lo = int'(regs.min_freq_chz);
                        hi = int'(regs.max_freq_chz);
                        x  = lo + 2 * (int'(regs.target_pressure_mbar) -
                                       int'(w.pressure_mbar));
                        if (x < lo)
                            x = lo;
                        else if (x > hi)
                            x = hi;
                        st.freq_now = x[FREQ_W-1:0];
                    end
                end

                // Protections: all checks run when the pump runs after the house logic
                if (w.emergency_stop) begin
                    st.run_flag = 1'b0;
                end else if (st.run_flag) begin
                    if (w.current_ca >= regs.emergency_current_ca) begin
                        trip();
                        trips[TRIP_EMERGENCY] = 1'b1;
                    end
                    if (w.current_ca >= regs.overload_current_ca) begin
                        if (st.overload_start_ms == 0)
                            st.overload_start_ms = w.now_ms;
                        if (w.now_ms - st.overload_start_ms > OVERLOAD_DELAY_MS) begin
                            trip();
                            trips[TRIP_OVERLOAD] = 1'b1;
                        end
                    end else begin
                        st.overload_start_ms = '0;
                    end
                    if (w.current_ca < regs.dry_current_ca) begin
                        if (st.dry_start_ms == 0)
                            st.dry_start_ms = w.now_ms;
                        if (w.now_ms - st.dry_start_ms > DRY_DELAY_MS) begin
                            trip();
                            trips[TRIP_DRY] = 1'b1;
                        end
                    end else begin
                        st.dry_start_ms = '0;
                    end
                    if (w.now_ms - st.run_start_ms > STARTUP_GRACE_MS &&
                        w.current_ca <= NO_CURRENT_CA) begin
                        trip();
                        trips[TRIP_NO_CURRENT] = 1'b1;
                    end
                    if (w.pressure_mbar >= TRIP_PRESSURE_MBAR) begin
                        trip();
                        trips[TRIP_OVERPRESSURE] = 1'b1;
                    end
                end
            end
        endcase

        r.pump_run       = st.run_flag;
        r.drive_freq_chz = st.freq_now;
        r.pump_blocked   = st.blocked_flag;
        r.pump_alarm     = st.alarm_flag;
        r.force_active   = st.force_flag;
        r.trip_flags     = trips;
        pending_results.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_word(result_t got);
        result_t want;
        if (pending_results.size() == 0) begin
            report("status word with no sensor word outstanding");
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (got.pump_run !== want.pump_run)
            report($sformatf("word %0d pump_run %0d, want %0d",
                             checked, got.pump_run, want.pump_run));
        if (got.drive_freq_chz !== want.drive_freq_chz)
            report($sformatf("word %0d drive_freq_chz %0d, want %0d",
                             checked, got.drive_freq_chz, want.drive_freq_chz));
        if (got.pump_blocked !== want.pump_blocked)
            report($sformatf("word %0d pump_blocked %0d, want %0d",
                             checked, got.pump_blocked, want.pump_blocked));
        if (got.pump_alarm !== want.pump_alarm)
            report($sformatf("word %0d pump_alarm %0d, want %0d",
                             checked, got.pump_alarm, want.pump_alarm));
        if (got.force_active !== want.force_active)
            report($sformatf("word %0d force_active %0d, want %0d",
                             checked, got.force_active, want.force_active));
        if (got.trip_flags !== want.trip_flags)
            report($sformatf("word %0d trip_flags %b, want %b",
                             checked, got.trip_flags, want.trip_flags));
    endtask
endclass

module house_pressure_pump_controller_test;

    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned PHASE_WORDS  = 150;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pump_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_stall = 0;
    logic [TIME_W-1:0] wall_ms = 32'd1000;
    int unsigned pres_mode = 0;
    int unsigned curr_mode = 5;

    house_pressure_pump_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge aclk) begin
        result_t got;
        item_t   w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.pump_run       = m_tdata[0];
                got.drive_freq_chz = m_tdata[14:1];
                got.pump_blocked   = m_tdata[15];
                got.pump_alarm     = m_tdata[16];
                got.force_active   = m_tdata[17];
                got.trip_flags     = m_tdata[22:18];
                sb.check_word(got);
            end
            if (s_tvalid && s_tready) begin
                w.action           = s_tuser;
                w.now_ms           = s_tdata[31:0];
                w.emergency_stop   = s_tdata[32];
                w.telemetry_valid  = s_tdata[33];
                w.level_low_sensor = s_tdata[34];
                w.level_mid_sensor = s_tdata[35];
                w.pressure_mbar    = s_tdata[49:36];
                w.current_ca       = s_tdata[62:50];
                sb.note_word(w);
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_stall != 0) begin
                m_tready = 1'b0;
                rx_stall--;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready = 1'b0;
                rx_stall = $urandom_range(1, 12) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Present one word, with an optional idle burst ahead of it; hold until taken
    task send_word(item_t w);
        @(negedge aclk);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = w.action;
        s_tdata  = {1'b0, w.current_ca, w.pressure_mbar, w.level_mid_sensor,
                    w.level_low_sensor, w.telemetry_valid, w.emergency_stop, w.now_ms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task send_tick(logic [31:0] now, logic estop, logic valid, logic lvl_low, logic lvl_mid,
                   int unsigned pres, int unsigned curr);
        item_t w;
        w.action           = ACT_TICK;
        w.now_ms           = now;
        w.emergency_stop   = estop;
        w.telemetry_valid  = valid;
        w.level_low_sensor = lvl_low;
        w.level_mid_sensor = lvl_mid;
        w.pressure_mbar    = pres[PRES_W-1:0];
        w.current_ca       = curr[CURR_W-1:0];
        send_word(w);
    endtask

    // Command words carry random sensor content that must be ignored
    task send_command(action_t act);
        item_t w;
        w = item_t'({$urandom, $urandom});
        w.action = act;
        send_word(w);
    endtask

    // Drop valid and wait until every status word is back
    task drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_reg(cfg_idx_t idx, int unsigned v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = v[CFG_DATA_W-1:0];
        sb.write_reg(idx, v[CFG_DATA_W-1:0]);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task set_regs(int unsigned start_p, int unsigned stop_p, int unsigned target_p,
                  int unsigned min_f, int unsigned max_f, int unsigned emerg_c,
                  int unsigned over_c, int unsigned dry_c);
        write_reg(CFG_START_PRESSURE, start_p);
        write_reg(CFG_STOP_PRESSURE, stop_p);
        write_reg(CFG_TARGET_PRESSURE, target_p);
        write_reg(CFG_MIN_FREQ, min_f);
        write_reg(CFG_MAX_FREQ, max_f);
        write_reg(CFG_EMERGENCY_CURRENT, emerg_c);
        write_reg(CFG_OVERLOAD_CURRENT, over_c);
        write_reg(CFG_DRY_CURRENT, dry_c);
    endtask

    // Random value around a threshold, kept inside the field
    function automatic int unsigned near(int centre, int spread, int top);
        int v;
        v = centre - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        if (v > top)
            v = top;
        return v;
    endfunction

    // Mostly plausible ticks with sticky pressure and current regimes, so that
    // the timed protections get the chance to mature; some commands and noise
    function automatic item_t random_word();
        item_t       w;
        int unsigned r;

        r = $urandom_range(0, 99);
        if (sb.st.blocked_flag && $urandom_range(0, 2) == 0)
            w.action = ACT_CLEAR;
        else if (r < 6)
            w.action = ACT_FORCE_ON;
        else if (r < 10)
            w.action = ACT_FORCE_OFF;
        else if (r < 14)
            w.action = ACT_CLEAR;
        else
            w.action = ACT_TICK;

        // Advance the millisecond clock, now and then jump or hit zero
        r = $urandom_range(0, 99);
        if (r < 70)
            wall_ms = wall_ms + $urandom_range(1, 1500);
        else if (r < 85)
            wall_ms = wall_ms + $urandom_range(3000, 12000);
        else if (r < 90)
            wall_ms = wall_ms;
        else if (r < 95)
            wall_ms = '0;
        else
            wall_ms = $urandom;
        w.now_ms = wall_ms;

        w.emergency_stop   = ($urandom_range(0, 99) < 3);
        w.telemetry_valid  = ($urandom_range(0, 99) >= 4);
        w.level_low_sensor = ($urandom_range(0, 99) >= 4);
        w.level_mid_sensor = ($urandom_range(0, 99) >= 4);

        if ($urandom_range(0, 5) == 0)
            pres_mode = $urandom_range(0, 5);
        case (pres_mode)
            0: r = near(sb.regs.start_pressure_mbar, 300, 16383);
            1: r = near(sb.regs.stop_pressure_mbar, 300, 16383);
            2: r = near(sb.regs.target_pressure_mbar, 1500, 16383);
            3: r = near(TRIP_PRESSURE_MBAR, 30, 16383);
            4: r = $urandom_range(0, 16383);
            default: r = near(sb.regs.start_pressure_mbar, 40, 16383);
        endcase
        w.pressure_mbar = r[PRES_W-1:0];

        if ($urandom_range(0, 5) == 0)
            curr_mode = $urandom_range(0, 7);
        case (curr_mode)
            0: r = $urandom_range(0, 6);
            1: r = near(sb.regs.dry_current_ca, 20, 8191);
            2: r = near(sb.regs.overload_current_ca, 30, 8191);
            3: r = near(sb.regs.emergency_current_ca, 30, 8191);
            4: r = $urandom_range(0, 8191);
            default: r = $urandom_range(sb.regs.dry_current_ca, sb.regs.overload_current_ca);
        endcase
        w.current_ca = r[CURR_W-1:0];
        return w;
    endfunction

    initial begin
        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed walk through the special cases on reset thresholds
        send_tick(32'd100, 0, 1, 1, 1, 1500, 500);       // start, command clamped to max
        send_tick(32'd200, 0, 1, 1, 1, 3200, 500);       // command clamped to min
        send_tick(32'd300, 0, 1, 1, 1, 3500, 500);       // stop at threshold
        send_tick(32'd400, 0, 1, 1, 1, 2000, 1600);      // start at threshold, overload timer
        send_tick(32'd5400, 0, 1, 1, 1, 2500, 1600);     // overload delay just met
        send_tick(32'd5401, 0, 1, 1, 1, 2500, 1600);     // overload delay exceeded
        send_tick(32'd5500, 0, 1, 1, 1, 1000, 500);      // blocked, stays off
        send_command(ACT_CLEAR);
        send_tick(32'd5600, 0, 1, 1, 1, 1000, 2000);     // emergency with stale overload timer
        send_command(ACT_CLEAR);
        send_command(ACT_FORCE_ON);
        send_tick(32'd5700, 0, 1, 0, 0, 9000, 0);        // forced on dry tank, overpressure
        send_command(ACT_CLEAR);
        send_tick(32'd5800, 0, 1, 1, 0, 1000, 500);      // no water
        send_tick(32'd0, 0, 1, 1, 1, 1000, 100);         // timers started at zero
        send_tick(32'd20, 0, 1, 1, 1, 16383, 8191);      // field maxima, pump stops
        send_command(ACT_FORCE_ON);
        send_tick(32'd40, 0, 1, 1, 1, 16383, 8191);      // forced, emergency and overpressure trips at once
        send_command(ACT_CLEAR);
        send_tick(32'hFFFF_FFF0, 0, 1, 1, 1, 0, 3);      // start just before wrap
        send_tick(32'h0000_1400, 1, 1, 1, 1, 0, 3);      // emergency stop while running
        send_tick(32'h0000_1500, 0, 0, 1, 1, 0, 3);      // telemetry invalid
        send_command(ACT_FORCE_OFF);
        send_tick(32'h0000_1600, 0, 1, 1, 1, 0, 3);      // restart with no current
        send_tick(32'h0000_3000, 0, 1, 1, 1, 100, 4);    // no current after grace time
        drain();

        // Random phases, each under its own thresholds and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 15;
                end
                1: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    set_regs($urandom_range(1000, 4000), $urandom_range(4000, 6000),
                             $urandom_range(2000, 5000), $urandom_range(0, 4000),
                             $urandom_range(4000, 10000), $urandom_range(1500, 5000),
                             $urandom_range(500, 1500), $urandom_range(0, 500));
                end
                2: begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 10;
                    set_regs(0, 0, 0, 0, 0, 0, 0, 0);
                end
                3: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 30;
                    wall_ms = 32'hFFFF_C000;
                    set_regs(16000, 16000, 16000, 10000, 10000, 5000, 5000, 5000);
                end
                4: begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 25;
                    // Minimum frequency above the maximum
                    set_regs(2000, 3500, 3000, 8000, 2000, 2000, 1500, 200);
                end
                5: begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 40;
                    set_regs($urandom_range(0, 16000), $urandom_range(0, 16000),
                             $urandom_range(0, 16000), $urandom_range(0, 10000),
                             $urandom_range(0, 10000), $urandom_range(0, 5000),
                             $urandom_range(0, 5000), $urandom_range(0, 5000));
                end
                6: begin
                    tx_idle_pct = 40;
                    rx_idle_pct = 20;
                    set_regs($urandom_range(1000, 4000), $urandom_range(3000, 7000),
                             $urandom_range(2000, 5000), $urandom_range(0, 5000),
                             $urandom_range(2000, 10000), $urandom_range(1000, 5000),
                             $urandom_range(300, 3000), $urandom_range(0, 800));
                end
                default: begin
                    // Closing stretch at full rate on the reset thresholds
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    set_regs(RST_START_PRESSURE, RST_STOP_PRESSURE, RST_TARGET_PRESSURE,
                             RST_MIN_FREQ, RST_MAX_FREQ, RST_EMERGENCY_CURRENT,
                             RST_OVERLOAD_CURRENT, RST_DRY_CURRENT);
                end
            endcase
            repeat (PHASE_WORDS) send_word(random_word());
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.pending_results.size() != 0)
            sb.report("status words still outstanding at the end");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/hppc_pkg.sv
hw/rtl/hppc_cfg.sv
hw/rtl/hppc_step.sv
hw/rtl/house_pressure_pump_controller.sv
tb/sv/house_pressure_pump_controller_test.sv
